FILE: src/acm_pkg.sv
// Shared constants, types and the cosine table of the AM carrier mixer.
`timescale 1ns / 1ps

package acm_pkg;

	// Datapath sizing.
	localparam int PHASE_BITS      = 32;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int SAMPLE_BITS     = 16;
	localparam int TABLE_DEPTH     = 1 << TABLE_ADDR_BITS;

	// Port field widths.
	localparam int MSG_W      = 16;
	localparam int OUT_W      = 24;
	localparam int STEP_W     = 32;
	localparam int AMP_W      = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 48;

	// Internal arithmetic widths.
	localparam int COS_W     = 16;
	localparam int CARRIER_W = AMP_W + COS_W;
	localparam int PROD_W    = SAMPLE_BITS + CARRIER_W;
	localparam int MOD_SHIFT = 23;
	localparam int CAR_SHIFT = 8;

	// Rescaling of the 32-bit phase step to the accumulator width.
	localparam int STEP_LSH = (PHASE_BITS >= STEP_W) ? PHASE_BITS - STEP_W : 0;
	localparam int STEP_RSH = (PHASE_BITS < STEP_W) ? STEP_W - PHASE_BITS : 0;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP        = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CARRIER_AMPLITUDE = CFG_IDX_W'(1);
	localparam logic [AMP_W-1:0]     AMP_RESET             = AMP_W'(256);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // take an input beat and advance the phase
		logic rom_rd;    // look up the cosine
		logic car_mul;   // amplitude times cosine
		logic prod_mul;  // sample times carrier
		logic out_load;  // saturate and fill the output register
	} acm_cmd_t;

	// CORDIC constants used to build the cosine table.
	localparam int     CORDIC_ITERS = 24;
	localparam longint CORDIC_GAIN  = 64'sd652032874;
	localparam longint ATAN_TURNS [CORDIC_ITERS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	typedef logic signed [COS_W-1:0] cos_rom_t [TABLE_DEPTH];

	// Q1.15 cosine of table entry k, from a Q2.30 CORDIC after a quadrant fold.
	function automatic logic signed [COS_W-1:0] cos_entry(int k);
		longint theta;
		longint z;
		longint x;
		longint y;
		longint xn;
		longint c;
		longint r;
		int     quad;
		theta = (longint'(k) << (32 - TABLE_ADDR_BITS)) & 64'h0000_0000_FFFF_FFFF;
		quad  = int'(theta >> 30);
		z     = theta & 64'h0000_0000_3FFF_FFFF;
		x     = CORDIC_GAIN;
		y     = 0;
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			if (z >= 0) begin
				xn = x - (y >>> i);
				y  = y + (x >>> i);
				z  = z - ATAN_TURNS[i];
			end else begin
				xn = x + (y >>> i);
				y  = y - (x >>> i);
				z  = z + ATAN_TURNS[i];
			end
			x = xn;
		end
		case (quad)
			0:       c = x;
			1:       c = -y;
			2:       c = -x;
			default: c = y;
		endcase
		r = (c + 64'sd16384) >>> 15;
		if (r > 64'sd32767) begin
			r = 64'sd32767;
		end else if (r < -64'sd32768) begin
			r = -64'sd32768;
		end
		return COS_W'(r);
	endfunction

	function automatic cos_rom_t build_cos_rom();
		cos_rom_t t;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			t[k] = cos_entry(k);
		end
		return t;
	endfunction

	// Constant cosine table, evaluated at elaboration.
	localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

FILE: src/acm_ctrl.sv
// Controller of the AM carrier mixer: sequences one sample through the datapath.
`timescale 1ns / 1ps

module acm_ctrl
	import acm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output acm_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ROM  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_PROD = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_free;
	logic       m_tvalid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_ROM;
				end
			end
			ST_ROM: begin
				cmd.rom_rd = 1'b1;
				state_d    = ST_MUL;
			end
			ST_MUL: begin
				cmd.car_mul = 1'b1;
				state_d     = ST_PROD;
			end
			ST_PROD: begin
				cmd.prod_mul = 1'b1;
				state_d      = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: src/acm_datapath.sv
// Datapath of the AM carrier mixer: registers, phase accumulator, table and multipliers.
`timescale 1ns / 1ps

module acm_datapath
	import acm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  acm_cmd_t              cmd,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [MSG_W-1:0]      message_sample,
	input  logic                  first_sample,
	output logic [OUT_W-1:0]      modulated_sample,
	output logic [OUT_W-1:0]      carrier_value
);

	localparam logic signed [PROD_W-1:0]    MOD_MAX = PROD_W'((1 <<< (OUT_W - 1)) - 1);
	localparam logic signed [PROD_W-1:0]    MOD_MIN = -PROD_W'(1 <<< (OUT_W - 1));
	localparam logic signed [CARRIER_W-1:0] CAR_MAX = CARRIER_W'((1 <<< (OUT_W - 1)) - 1);
	localparam logic signed [CARRIER_W-1:0] CAR_MIN = -CARRIER_W'(1 <<< (OUT_W - 1));

	logic [STEP_W-1:0]                 phase_step_q;
	logic [AMP_W-1:0]                  amplitude_q;
	logic [PHASE_BITS-1:0]             phase_q;
	logic [PHASE_BITS-1:0]             phase_now;
	logic [PHASE_BITS-1:0]             step;
	logic [PHASE_BITS+STEP_W-1:0]      step_wide;
	logic [TABLE_ADDR_BITS-1:0]        addr_q;
	logic signed [SAMPLE_BITS-1:0]     sample_q;
	logic signed [COS_W-1:0]           cos_q;
	logic signed [CARRIER_W-1:0]       carrier_q;
	logic signed [PROD_W-1:0]          prod_q;
	logic signed [PROD_W-1:0]          mod_shift;
	logic signed [CARRIER_W-1:0]       car_shift;
	logic signed [OUT_W-1:0]           mod_sat;
	logic signed [OUT_W-1:0]           car_sat;
	logic [OUT_W-1:0]                  mod_q;
	logic [OUT_W-1:0]                  car_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			amplitude_q  <= AMP_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_PHASE_STEP) begin
				phase_step_q <= cfg_data[STEP_W-1:0];
			end else if (cfg_index == REG_CARRIER_AMPLITUDE) begin
				amplitude_q <= cfg_data[AMP_W-1:0];
			end
		end
	end

	// Phase step rescaled to the accumulator width; phase cleared on a first sample.
	assign step_wide = (PHASE_BITS + STEP_W)'(phase_step_q) << STEP_LSH;
	assign step      = PHASE_BITS'(step_wide >> STEP_RSH);
	assign phase_now = first_sample ? '0 : phase_q;

	// Phase accumulator; the table address is taken from the phase before the step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (cmd.load) begin
			phase_q <= phase_now + step;
		end
	end

	// Input capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q   <= phase_now[PHASE_BITS-1 -: TABLE_ADDR_BITS];
			sample_q <= signed'(SAMPLE_BITS'(message_sample));
		end
	end

	// Registered cosine lookup.
	always_ff @(posedge clk) begin
		if (cmd.rom_rd) begin
			cos_q <= COS_ROM[addr_q];
		end
	end

	// Carrier: unsigned Q8.8 amplitude times Q1.15 cosine.
	always_ff @(posedge clk) begin
		if (cmd.car_mul) begin
			carrier_q <= CARRIER_W'(signed'({1'b0, amplitude_q})) * CARRIER_W'(cos_q);
		end
	end

	// Sample times carrier.
	always_ff @(posedge clk) begin
		if (cmd.prod_mul) begin
			prod_q <= PROD_W'(sample_q) * PROD_W'(carrier_q);
		end
	end

	// Shift and saturate both results.
	assign mod_shift = prod_q >>> MOD_SHIFT;
	assign car_shift = carrier_q >>> CAR_SHIFT;

	always_comb begin
		if (mod_shift > MOD_MAX) begin
			mod_sat = OUT_W'(MOD_MAX);
		end else if (mod_shift < MOD_MIN) begin
			mod_sat = OUT_W'(MOD_MIN);
		end else begin
			mod_sat = OUT_W'(mod_shift);
		end
		if (car_shift > CAR_MAX) begin
			car_sat = OUT_W'(CAR_MAX);
		end else if (car_shift < CAR_MIN) begin
			car_sat = OUT_W'(CAR_MIN);
		end else begin
			car_sat = OUT_W'(car_shift);
		end
	end

	// Output register, held while the result beat waits.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mod_q <= mod_sat;
			car_q <= car_sat;
		end
	end

	assign modulated_sample = mod_q;
	assign carrier_value    = car_q;

endmodule

FILE: src/am_carrier_mixer.sv
// Top level of the AM carrier mixer: controller, datapath and port packing.
//
//   channel  dir  handshake                      payload
//   s_*      in   s_tvalid / s_tready            s_tdata: message_sample, s_tuser: first_sample
//   m_*      out  m_tvalid / m_tready            m_tdata: modulated_sample, carrier_value
//   cfg_*    in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
// Each sample passes these steps from the input beat to the output register:
// capture and phase step, table read, carrier multiply, product multiply, saturate.
// A new sample is taken once the previous one has reached the output register.
// A stalled output beat holds the last stage until the output register frees up.
// arst_n clears the phase, the controller and restores the register reset values.
// Configuration writes are taken in every cycle.
`timescale 1ns / 1ps

module am_carrier_mixer
	import acm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // [15:0] message_sample
	input  logic                  s_tuser,   // [0] first_sample
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // [23:0] modulated_sample, [47:24] carrier_value
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	acm_cmd_t         cmd;
	logic [OUT_W-1:0] modulated_sample;
	logic [OUT_W-1:0] carrier_value;

	assign cfg_ready = 1'b1;

	acm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	acm_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg_we           (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.message_sample   (s_tdata[MSG_W-1:0]),
		.first_sample     (s_tuser),
		.modulated_sample (modulated_sample),
		.carrier_value    (carrier_value)
	);

	assign m_tdata = {carrier_value, modulated_sample};

endmodule

FILE: src/acm_checker.sv
// Port-level checks of the AM carrier mixer, bound to the top level.
`timescale 1ns / 1ps

module acm_checker
	import acm_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [M_TDATA_W-1:0]  m_tdata,
	input logic                  cfg_valid,
	input logic                  cfg_ready
);

	// A stalled output beat keeps its valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	// A stalled output beat keeps its data.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output data changed while stalled");

	// After an input beat the block stays busy through the table read, multiply and output states.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready)
		else $error("input taken while a sample is in flight");

	// A fresh output beat must be traced back to a matching input beat.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 5))
		else $error("output beat without matching input beat");

	// The configuration port never stalls.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind am_carrier_mixer acm_checker u_acm_checker (.*);
